FILE: rtl/core/binary_image_block_majority_defines.svh
// ----------------------------------------------------------------------------
// Binary image block majority - assertion macros
// Shared property shapes for the checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_IMAGE_BLOCK_MAJORITY_DEFINES_SVH
`define BINARY_IMAGE_BLOCK_MAJORITY_DEFINES_SVH

// same-cycle implication
`define BIBM_ASSERT_IMPLY(name, clk, rst, cond, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define BIBM_ASSERT_NEXT(name, clk, rst, cond, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: rtl/core/bibm_pkg.sv
// ----------------------------------------------------------------------------
// bibm_pkg
// Shared constants and the segment descriptor of the block majority core.
// ----------------------------------------------------------------------------
package bibm_pkg;

   localparam int DEF_IMAGE_WIDTH  = 256;
   localparam int DEF_IMAGE_HEIGHT = 128;
   localparam int DEF_MAX_BLOCK    = 16;
   localparam int QUEUE_DEPTH      = 4;

   localparam int CFG_W  = 5;
   localparam int PIX_W  = 8;
   localparam int BCOL_W = 8;
   localparam int BROW_W = 7;
   localparam int NPIX_W = 4;

   // one run of pixels of a word that falls into a single block column
   typedef struct packed {
      logic [NPIX_W-1:0] npix;
      logic [NPIX_W-1:0] nblack;
      logic              first;
      logic              emit;
      logic              row_end;
      logic              frame_end;
      logic              last;
      logic [BROW_W-1:0] band;
   } seg_info_type;

endpackage

FILE: rtl/core/bibm_req_if.sv
// ----------------------------------------------------------------------------
// bibm_req_if
// Pixel word channel: valid/ready with one byte of pixels.
// ----------------------------------------------------------------------------
interface bibm_req_if;
   import bibm_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_byte;
   logic             frame_start;

   modport source (output valid, pixel_byte, frame_start, input ready);
   modport sink (input valid, pixel_byte, frame_start, output ready);
   modport monitor (input valid, ready, pixel_byte, frame_start);

endinterface

FILE: rtl/core/bibm_rsp_if.sv
// ----------------------------------------------------------------------------
// bibm_rsp_if
// Block decision channel: valid/ready with one block decision per transfer.
// ----------------------------------------------------------------------------
interface bibm_rsp_if;
   import bibm_pkg::*;

   logic              valid;
   logic              ready;
   logic [BCOL_W-1:0] block_col;
   logic [BROW_W-1:0] block_row;
   logic              is_black;
   logic              row_end;
   logic              frame_end;
   logic              last;

   modport source (output valid, block_col, block_row, is_black, row_end, frame_end, last,
                   input ready);
   modport sink (input valid, block_col, block_row, is_black, row_end, frame_end, last,
                 output ready);
   modport monitor (input valid, ready, block_col, block_row, is_black, row_end,
                    frame_end, last);

endinterface

FILE: rtl/core/binary_image_block_majority.sv
// ----------------------------------------------------------------------------
// binary_image_block_majority
// Majority pooling of a 1-bit frame into square blocks. Pixel words arrive in
// raster order (MSB leftmost, 0 = black); one decision comes out per block,
// on the last pixel row of each band. The front walks a word as runs of
// pixels, one run per touched block column per cycle while the queue has
// room, so a word is cut into 1 to 8 runs (8 only when every pixel is its
// own block). The count engine retires one run per cycle while the result
// port is free, with one read and one write of the column count memory per
// run; the result port gives at most one decision per cycle. A four-entry
// queue between the two lets the walker take the next word while decisions
// wait. A column high-water mark makes untouched columns read as zero, so
// band, frame and reset need no clearing pass. The user writes block_size
// through csr_wr_en/csr_wr_data while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module binary_image_block_majority #(
   parameter int IMAGE_WIDTH  = bibm_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = bibm_pkg::DEF_IMAGE_HEIGHT,
   parameter int MAX_BLOCK    = bibm_pkg::DEF_MAX_BLOCK
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [bibm_pkg::CFG_W-1:0] csr_wr_data,
   bibm_req_if.sink                   req_bus,
   bibm_rsp_if.source                 rsp_bus
);
   import bibm_pkg::*;

   localparam int COL_W  = $clog2(IMAGE_WIDTH);
   localparam int ENTRY_W = COL_W + $bits(seg_info_type);

   logic               fr_valid;
   logic               fr_ready;
   logic [COL_W-1:0]   fr_col;
   seg_info_type       fr_info;
   logic               bk_valid;
   logic               bk_ready;
   logic [ENTRY_W-1:0] bk_data;
   seg_info_type       bk_info;
   logic [COL_W-1:0]   bk_col;

   bibm_front #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT),
      .MAX_BLOCK    (MAX_BLOCK),
      .COL_W        (COL_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .seg_valid   (fr_valid),
      .seg_ready   (fr_ready),
      .seg_col     (fr_col),
      .seg_info    (fr_info)
   );

   bibm_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_valid),
      .push_ready (fr_ready),
      .push_data  ({fr_col, fr_info}),
      .pop_valid  (bk_valid),
      .pop_ready  (bk_ready),
      .pop_data   (bk_data)
   );

   assign bk_col  = bk_data[ENTRY_W-1 -: COL_W];
   assign bk_info = seg_info_type'(bk_data[$bits(seg_info_type)-1:0]);

   bibm_back #(
      .IMAGE_WIDTH (IMAGE_WIDTH),
      .MAX_BLOCK   (MAX_BLOCK),
      .COL_W       (COL_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (bk_valid),
      .seg_ready (bk_ready),
      .seg_col   (bk_col),
      .seg_info  (bk_info),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: rtl/core/bibm_queue.sv
// ----------------------------------------------------------------------------
// bibm_queue
// Small register FIFO between the segment walker and the count engine.
// ----------------------------------------------------------------------------
module bibm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bibm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/bibm_front.sv
// ----------------------------------------------------------------------------
// bibm_front
// Takes pixel words, tracks frame position and cuts each word into runs,
// one per touched block column, one run per cycle while seg_ready is high.
// ----------------------------------------------------------------------------
module bibm_front #(
   parameter int IMAGE_WIDTH  = bibm_pkg::DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = bibm_pkg::DEF_IMAGE_HEIGHT,
   parameter int MAX_BLOCK    = bibm_pkg::DEF_MAX_BLOCK,
   parameter int COL_W        = $clog2(IMAGE_WIDTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [bibm_pkg::CFG_W-1:0]  csr_wr_data,
   bibm_req_if.sink                    req_bus,
   output logic                        seg_valid,
   input  logic                        seg_ready,
   output logic [COL_W-1:0]            seg_col,
   output bibm_pkg::seg_info_type      seg_info
);
   import bibm_pkg::*;

   localparam int ROW_BYTES = (IMAGE_WIDTH + PIX_W - 1) / PIX_W;
   localparam int LAST_BITS = IMAGE_WIDTH - (ROW_BYTES - 1) * PIX_W;
   localparam int BC_W      = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
   localparam int PR_W      = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
   localparam int RWB_W     = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam int S_W       = $clog2(MAX_BLOCK + PIX_W + 1) + 1;
   localparam int POS_W     = $clog2(PIX_W);

   logic [CFG_W-1:0] bs_cfg_ff;
   logic [PIX_W-1:0] pix_ff;
   logic             busy_ff;
   logic [POS_W-1:0] pos_ff;
   logic [BC_W-1:0]  bcol_ff;
   logic [PR_W-1:0]  prow_ff;
   logic [RWB_W-1:0] rwb_ff;
   logic [PR_W-1:0]  band_ff;
   logic [S_W-1:0]   cwb_ff;
   logic [COL_W-1:0] blk_ff;
   logic [COL_W-1:0] hwm_ff;
   logic             fresh_ff;

   logic [S_W-1:0]    cfg_ext;
   logic [S_W-1:0]    bs;
   logic              row_last;
   logic              frame_last_row;
   logic              band_last;
   logic [S_W-1:0]    avail;
   logic [S_W-1:0]    need;
   logic [S_W-1:0]    len;
   logic [S_W-1:0]    rest;
   logic              end_byte;
   logic              row_edge;
   logic              closes;
   logic              emit;
   logic              more;
   logic              first;
   logic [NPIX_W-1:0] nblack;
   logic              push;
   logic              done;
   logic              accept;

   assign cfg_ext        = S_W'(bs_cfg_ff);
   assign bs             = (cfg_ext == '0) ? S_W'(1) :
                           (cfg_ext > S_W'(MAX_BLOCK)) ? S_W'(MAX_BLOCK) : cfg_ext;
   assign row_last       = (bcol_ff == BC_W'(ROW_BYTES - 1));
   assign frame_last_row = (prow_ff == PR_W'(IMAGE_HEIGHT - 1));
   assign band_last      = (S_W'(rwb_ff) + S_W'(1) >= bs) || frame_last_row;
   assign avail          = (row_last ? S_W'(LAST_BITS) : S_W'(PIX_W)) - S_W'(pos_ff);
   assign need           = (cwb_ff < bs) ? bs - cwb_ff : S_W'(1);
   assign len            = (need < avail) ? need : avail;
   assign rest           = avail - len;
   assign end_byte       = (len == avail);
   assign row_edge       = row_last && end_byte;
   assign closes         = (cwb_ff + len >= bs) || row_edge;
   assign emit           = closes && band_last;
   assign more           = emit && ((rest >= bs) || ((rest != '0) && row_last));
   assign first          = fresh_ff || (blk_ff > hwm_ff);

   always_comb begin
      nblack = '0;
      for (int i = 0; i < PIX_W; i++) begin
         if ((S_W'(i) >= S_W'(pos_ff)) && (S_W'(i) < S_W'(pos_ff) + len) &&
             !pix_ff[PIX_W-1-i]) begin
            nblack = nblack + NPIX_W'(1);
         end
      end
   end

   assign seg_valid          = busy_ff;
   assign seg_col            = blk_ff;
   assign seg_info.npix      = NPIX_W'(len);
   assign seg_info.nblack    = nblack;
   assign seg_info.first     = first;
   assign seg_info.emit      = emit;
   assign seg_info.row_end   = row_edge;
   assign seg_info.frame_end = row_edge && frame_last_row;
   assign seg_info.last      = emit && !more;
   assign seg_info.band      = BROW_W'(band_ff);

   assign push          = busy_ff && seg_ready;
   assign done          = push && end_byte;
   assign req_bus.ready = !reset && (!busy_ff || done);
   assign accept        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_cfg_ff <= CFG_W'(1);
         busy_ff   <= 1'b0;
         pos_ff    <= '0;
         bcol_ff   <= '0;
         prow_ff   <= '0;
         rwb_ff    <= '0;
         band_ff   <= '0;
         cwb_ff    <= '0;
         blk_ff    <= '0;
         hwm_ff    <= '0;
         fresh_ff  <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            bs_cfg_ff <= csr_wr_data;
         end
         if (push) begin
            if (first) begin
               hwm_ff   <= blk_ff;
               fresh_ff <= 1'b0;
            end
            cwb_ff <= closes ? '0 : cwb_ff + len;
            blk_ff <= blk_ff + COL_W'(closes);
            if (end_byte) begin
               pos_ff <= '0;
               if (row_last) begin
                  bcol_ff <= '0;
                  cwb_ff  <= '0;
                  blk_ff  <= '0;
                  if (frame_last_row) begin
                     prow_ff  <= '0;
                     rwb_ff   <= '0;
                     band_ff  <= '0;
                     fresh_ff <= 1'b1;
                  end else begin
                     prow_ff <= prow_ff + PR_W'(1);
                     if (band_last) begin
                        rwb_ff   <= '0;
                        band_ff  <= band_ff + PR_W'(1);
                        fresh_ff <= 1'b1;
                     end else begin
                        rwb_ff <= rwb_ff + RWB_W'(1);
                     end
                  end
               end else begin
                  bcol_ff <= bcol_ff + BC_W'(1);
               end
            end else begin
               pos_ff <= POS_W'(S_W'(pos_ff) + len);
            end
         end
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
         if (accept && req_bus.frame_start) begin
            pos_ff   <= '0;
            bcol_ff  <= '0;
            prow_ff  <= '0;
            rwb_ff   <= '0;
            band_ff  <= '0;
            cwb_ff   <= '0;
            blk_ff   <= '0;
            fresh_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff <= req_bus.pixel_byte;
      end
   end

endmodule

FILE: rtl/core/bibm_back.sv
// ----------------------------------------------------------------------------
// bibm_back
// Per-column count engine: read-modify-write of the column counts, majority
// decision and the registered result stage.
// ----------------------------------------------------------------------------
module bibm_back #(
   parameter int IMAGE_WIDTH = bibm_pkg::DEF_IMAGE_WIDTH,
   parameter int MAX_BLOCK   = bibm_pkg::DEF_MAX_BLOCK,
   parameter int COL_W       = $clog2(IMAGE_WIDTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   seg_valid,
   output logic                   seg_ready,
   input  logic [COL_W-1:0]       seg_col,
   input  bibm_pkg::seg_info_type seg_info,
   bibm_rsp_if.source             rsp_bus
);
   import bibm_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);

   logic [CNT_W-1:0] black_mem [IMAGE_WIDTH];
   logic [CNT_W-1:0] total_mem [IMAGE_WIDTH];

   logic [CNT_W-1:0] black_rd_ff;
   logic [CNT_W-1:0] total_rd_ff;
   logic [CNT_W-1:0] black_byp_ff;
   logic [CNT_W-1:0] total_byp_ff;
   logic             byp_ff;
   logic             b_valid_ff;
   seg_info_type     b_info_ff;
   logic [COL_W-1:0] b_col_ff;

   logic              rsp_valid_ff;
   logic [BCOL_W-1:0] col_ff;
   logic [BROW_W-1:0] row_ff;
   logic              black_ff;
   logic              row_end_ff;
   logic              frame_end_ff;
   logic              last_ff;

   logic             out_free;
   logic             b_fire;
   logic             pop;
   logic [CNT_W-1:0] black_base;
   logic [CNT_W-1:0] total_base;
   logic [CNT_W-1:0] black_sum;
   logic [CNT_W-1:0] total_sum;
   logic             decide;

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign b_fire     = b_valid_ff && (!b_info_ff.emit || out_free);
   assign seg_ready  = !b_valid_ff || b_fire;
   assign pop        = seg_valid && seg_ready;

   // first touch in a band reads as zero; back-to-back same column forwards
   assign black_base = b_info_ff.first ? '0 : (byp_ff ? black_byp_ff : black_rd_ff);
   assign total_base = b_info_ff.first ? '0 : (byp_ff ? total_byp_ff : total_rd_ff);
   assign black_sum  = black_base + CNT_W'(b_info_ff.nblack);
   assign total_sum  = total_base + CNT_W'(b_info_ff.npix);
   assign decide     = (total_sum != '0) && ({black_sum, 1'b0} >= {1'b0, total_sum});

   always_ff @(posedge clock) begin
      if (b_fire) begin
         black_mem[b_col_ff] <= black_sum;
         total_mem[b_col_ff] <= total_sum;
      end
      if (pop) begin
         black_rd_ff  <= black_mem[seg_col];
         total_rd_ff  <= total_mem[seg_col];
         byp_ff       <= b_fire && (b_col_ff == seg_col);
         black_byp_ff <= black_sum;
         total_byp_ff <= total_sum;
         b_info_ff    <= seg_info;
         b_col_ff     <= seg_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            b_valid_ff <= 1'b1;
         end else if (b_fire) begin
            b_valid_ff <= 1'b0;
         end
         if (b_fire && b_info_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire && b_info_ff.emit) begin
         col_ff       <= BCOL_W'(b_col_ff);
         row_ff       <= b_info_ff.band;
         black_ff     <= decide;
         row_end_ff   <= b_info_ff.row_end;
         frame_end_ff <= b_info_ff.frame_end;
         last_ff      <= b_info_ff.last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.block_col = col_ff;
   assign rsp_bus.block_row = row_ff;
   assign rsp_bus.is_black  = black_ff;
   assign rsp_bus.row_end   = row_end_ff;
   assign rsp_bus.frame_end = frame_end_ff;
   assign rsp_bus.last      = last_ff;

endmodule

FILE: rtl/core/bibm_checker.sv
// ----------------------------------------------------------------------------
// bibm_checker
// Port-level checks on the decision stream of the block majority core.
// ----------------------------------------------------------------------------
`include "binary_image_block_majority_defines.svh"

module bibm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bibm_pkg::BCOL_W-1:0] rsp_block_col,
   input logic                        rsp_row_end,
   input logic                        rsp_frame_end,
   input logic                        rsp_last
);

   `BIBM_ASSERT_IMPLY(a_fend_rend, clock, reset, rsp_valid && rsp_frame_end, rsp_row_end,
                      "frame end without row end")
   `BIBM_ASSERT_IMPLY(a_rend_last, clock, reset, rsp_valid && rsp_row_end, rsp_last,
                      "row end not last of word")
   `BIBM_ASSERT_IMPLY(a_rst_idle, clock, reset, $past(reset), !rsp_valid,
                      "result valid right after reset")
   `BIBM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_block_col) && $stable(rsp_last),
                     "stalled result changed")

endmodule

bind binary_image_block_majority bibm_checker u_bibm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_block_col (rsp_bus.block_col),
   .rsp_row_end   (rsp_bus.row_end),
   .rsp_frame_end (rsp_bus.frame_end),
   .rsp_last      (rsp_bus.last)
);

FILE: dv/binary_image_block_majority_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_image_block_majority_tb
// Streams 1-bit pixel words through the majority pooling block and checks
// every block decision in order against a predictor of the band counts.
// ----------------------------------------------------------------------------
module binary_image_block_majority_tb;
   import bibm_pkg::*;

   localparam int IMG_W       = DEF_IMAGE_WIDTH;
   localparam int IMG_H       = DEF_IMAGE_HEIGHT;
   localparam int BLOCK_MAX   = DEF_MAX_BLOCK;
   localparam int ROW_WORDS   = (IMG_W + 7) / 8;
   localparam int LATENCY_PAD = 48;

   typedef struct packed {
      logic [BCOL_W-1:0] col;
      logic [BROW_W-1:0] row;
      logic              black;
      logic              row_end;
      logic              frame_end;
      logic              last;
   } block_decision_type;

   class decision_board_type;
      int unsigned        black_cnt[IMG_W];
      int unsigned        pix_cnt[IMG_W];
      int unsigned        word_col;
      int unsigned        pix_row;
      int unsigned        row_in_band;
      int unsigned        band;
      int unsigned        col_in_block;
      int unsigned        block_col;
      logic [CFG_W-1:0]   size_reg;
      block_decision_type pending_decisions[$];
      int                 errors;
      int                 words;
      int                 decisions;

      function void clear_counts();
         foreach (black_cnt[i]) begin
            black_cnt[i] = 0;
            pix_cnt[i]   = 0;
         end
      endfunction

      function void restart_frame();
         clear_counts();
         word_col     = 0;
         pix_row      = 0;
         row_in_band  = 0;
         band         = 0;
         col_in_block = 0;
         block_col    = 0;
      endfunction

      function void reset_state();
         restart_frame();
         size_reg = 1;
         pending_decisions.delete();
      endfunction

      function void set_size(logic [CFG_W-1:0] v);
         size_reg = v;
      endfunction

      function int pending();
         return pending_decisions.size();
      endfunction

      function void note_word(logic [PIX_W-1:0] pix, logic fs);
         int unsigned        sz;
         int unsigned        x;
         int unsigned        c;
         bit                 band_last;
         bit                 row_edge;
         block_decision_type d;
         block_decision_type batch[$];
         words++;
         if (fs) restart_frame();
         sz = size_reg;
         if (sz < 1) sz = 1;
         if (sz > BLOCK_MAX) sz = BLOCK_MAX;
         band_last = (row_in_band + 1 >= sz) || (pix_row + 1 >= IMG_H);
         for (int i = 0; i < 8; i++) begin
            x = word_col * 8 + i;
            c = block_col;
            if (x >= IMG_W || c >= IMG_W) continue;
            pix_cnt[c]++;
            if (!pix[7-i]) black_cnt[c]++;
            col_in_block++;
            row_edge = (x + 1 == IMG_W);
            if (col_in_block >= sz || row_edge) begin
               if (band_last) begin
                  d.col       = BCOL_W'(c);
                  d.row       = BROW_W'(band);
                  d.black     = pix_cnt[c] != 0 && black_cnt[c] * 2 >= pix_cnt[c];
                  d.row_end   = row_edge;
                  d.frame_end = row_edge && (pix_row + 1 >= IMG_H);
                  d.last      = 1'b0;
                  batch.push_back(d);
               end
               col_in_block = 0;
               block_col++;
            end
         end
         if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
         foreach (batch[i]) pending_decisions.push_back(batch[i]);

         word_col++;
         if (word_col >= ROW_WORDS) begin
            word_col     = 0;
            col_in_block = 0;
            block_col    = 0;
            pix_row++;
            if (pix_row >= IMG_H) begin
               restart_frame();
            end else if (band_last) begin
               clear_counts();
               row_in_band = 0;
               band++;
            end else begin
               row_in_band++;
            end
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_decision(block_decision_type got);
         block_decision_type want;
         if (pending_decisions.size() == 0) begin
            errors++;
            $display("%0t: unexpected decision, expected none, got col %0d row %0d",
                     $time, got.col, got.row);
            return;
         end
         want = pending_decisions.pop_front();
         decisions++;
         compare_field("block_col", want.col, got.col);
         compare_field("block_row", want.row, got.row);
         compare_field("is_black", want.black, got.black);
         compare_field("row_end", want.row_end, got.row_end);
         compare_field("frame_end", want.frame_end, got.frame_end);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [CFG_W-1:0]   csr_wr_data;
   int                 send_gap_pct;
   int                 recv_stall_pct;
   int                 size_writes;
   decision_board_type board;
   block_decision_type seen;

   bibm_req_if req_bus();
   bibm_rsp_if rsp_bus();

   binary_image_block_majority u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #12_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // result side: random back-pressure and in-order checking
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.col       = rsp_bus.block_col;
            seen.row       = rsp_bus.block_row;
            seen.black     = rsp_bus.is_black;
            seen.row_end   = rsp_bus.row_end;
            seen.frame_end = rsp_bus.frame_end;
            seen.last      = rsp_bus.last;
            board.check_decision(seen);
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [PIX_W-1:0] pick_word();
      unique case ($urandom_range(5))
         0: return 8'h00;
         1: return 8'hFF;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   task automatic send_word(logic [PIX_W-1:0] pix, logic fs);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid       <= 1'b0;
         req_bus.pixel_byte  <= PIX_W'($urandom_range(255));
         req_bus.frame_start <= 1'($urandom_range(1));
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.pixel_byte  <= pix;
      req_bus.frame_start <= fs;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_word(pix, fs);
   endtask

   task automatic wait_results_done();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // words that close no block may still be in flight when the queue empties
   task automatic drain();
      wait_results_done();
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   task automatic write_size(logic [CFG_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_size(v);
      size_writes++;
   endtask

   task automatic run_random_phase(int n_words, bit pause_once);
      int               pause_at;
      logic [CFG_W-1:0] sz;
      logic             fs;
      if ($urandom_range(3) == 0) sz = CFG_W'($urandom_range(31));
      else sz = CFG_W'($urandom_range(3));
      write_size(sz);
      pause_at = pause_once ? $urandom_range(1, n_words - 1) : -1;
      for (int i = 0; i < n_words; i++) begin
         if (i == pause_at) wait_results_done();
         if (i == 0) fs = ($urandom_range(1) == 1);
         else fs = ($urandom_range(49) == 0);
         send_word(pick_word(), fs);
      end
      drain();
   endtask

   task automatic run_rows(int n_rows);
      for (int i = 0; i < n_rows * ROW_WORDS; i++) send_word(pick_word(), i == 0);
      drain();
   endtask

   initial begin
      board               = new();
      board.reset_state();
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.pixel_byte  <= '0;
      req_bus.frame_start <= 1'b0;
      send_gap_pct        = 11;
      recv_stall_pct      = 61;
      size_writes         = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, clamping, saturation, restart mid-row
      write_size(5'd1);
      send_word(8'h00, 1'b1);
      send_word(8'hFF, 1'b0);
      send_word(8'hAA, 1'b0);
      send_word(8'h55, 1'b0);
      send_word(8'h0F, 1'b1);
      drain();
      write_size(5'd0);
      send_word(8'hF0, 1'b0);
      send_word(8'h81, 1'b0);
      drain();
      write_size(5'd31);
      send_word(8'h7E, 1'b1);
      send_word(8'h01, 1'b0);
      drain();
      write_size(5'd17);
      send_word(8'h80, 1'b0);
      drain();
      write_size(5'd2);
      send_word(8'hC3, 1'b0);
      send_word(8'h3C, 1'b0);
      drain();

      for (int p = 0; p < 10; p++) begin
         if (p == 5) begin
            send_gap_pct   = 61;
            recv_stall_pct = 11;
         end
         run_random_phase($urandom_range(6, 14), p == 0 || $urandom_range(2) == 0);
      end

      // one full row at block size one, no idling on either side
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      write_size(5'd1);
      run_rows(1);

      $display("Ran %0d pixel words and checked %0d block decisions", board.words,
               board.decisions);
      $display("across %0d block size writes, with stalls on both sides and a full row",
               size_writes);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
